// ===== hw/rtl/spq_pkg.sv =====
// shared constants and types for the stable priority queue
package spq_pkg;

  localparam int CAPACITY       = 16;
  localparam int PRIORITY_WIDTH = 16;
  localparam int DATA_WIDTH     = 32;
  localparam int CNT_W          = $clog2(CAPACITY + 1);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [PRIORITY_WIDTH-1:0]    prio_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_POP    = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // per-cycle move applied to every cell of the chain
  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/stable_priority_queue.sv =====
// top level of the stable sorted priority queue
// Bounded queue of CAPACITY entries kept sorted in a chain of cells, highest priority at the
// front; equal priorities leave in arrival order. Every insert or pop word gives one result
// word carrying the popped data (zero otherwise), a status and the occupancy. All cells compare
// and shift together, so one word is taken per cycle while in_ready is high; its result
// appears in the output register on the next cycle. in_ready is high whenever the output
// register is empty or being taken in the same cycle. Inserting into a full queue or popping
// an empty one leaves the contents unchanged and is flagged in status.
module stable_priority_queue
  import spq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      cmd,
  input  logic signed [31:0]        entry_data,
  input  logic [15:0]               entry_priority,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [31:0]        front_data,
  output logic [1:0]                status,
  output logic [4:0]                occupancy
);

  cnt_t      count;
  cnt_t      count_next;
  cell_ctl_t ctl;
  logic      accept;
  logic      full;
  logic      empty;
  logic      is_pop;
  status_t   st_next;
  status_t   st_reg;
  data_t     front_next;

  logic  [CAPACITY-1:0] occ;
  logic  [CAPACITY-1:0] keep;
  data_t                cell_data [CAPACITY];
  prio_t                cell_prio [CAPACITY];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_pop   = (cmd_t'(cmd) == CMD_POP);
  assign full     = (count == cnt_t'(CAPACITY));
  assign empty    = (count == '0);

  assign ctl.insert = accept && !is_pop && !full;
  assign ctl.pop    = accept && is_pop && !empty;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic  l_keep;
      data_t l_data;
      prio_t l_prio;
      data_t r_data;
      prio_t r_prio;

      assign occ[i] = (cnt_t'(i) < count);

      if (i == 0) begin : g_front
        assign l_keep = 1'b1;
        assign l_data = '0;
        assign l_prio = '0;
      end else begin : g_mid
        assign l_keep = keep[i-1];
        assign l_data = cell_data[i-1];
        assign l_prio = cell_prio[i-1];
      end

      if (i == CAPACITY - 1) begin : g_back
        assign r_data = '0;
        assign r_prio = '0;
      end else begin : g_inner
        assign r_data = cell_data[i+1];
        assign r_prio = cell_prio[i+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occ        (occ[i]),
        .new_data   (entry_data),
        .new_prio   (entry_priority[PRIORITY_WIDTH-1:0]),
        .left_keep  (l_keep),
        .left_data  (l_data),
        .left_prio  (l_prio),
        .right_data (r_data),
        .right_prio (r_prio),
        .keep       (keep[i]),
        .data       (cell_data[i]),
        .prio       (cell_prio[i])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    st_next    = ST_OK;
    front_next = '0;
    if (is_pop) begin
      if (empty) begin
        st_next = ST_EMPTY;
      end else begin
        front_next = cell_data[0];
        count_next = count - cnt_t'(1);
      end
    end else begin
      if (full) begin
        st_next = ST_FULL;
      end else begin
        count_next = count + cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_data <= front_next;
      st_reg     <= st_next;
      occupancy  <= count_next;
    end
  end

  assign status = st_reg;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_pop && !full) |=> (count == $past(count) + cnt_t'(1)))
    else $error("insert did not grow the queue");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (accept && is_pop && !empty) |=> (count == $past(count) - cnt_t'(1)))
    else $error("pop did not shrink the queue");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> (out_valid && occupancy == count))
    else $error("result word missing or occupancy mismatch");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && st_reg == ST_EMPTY) |-> (occupancy == '0 && front_data == '0))
    else $error("empty pop reported with entries or data");
`endif

endmodule

// ===== hw/rtl/spq_cell.sv =====
// one slot of the sorted chain: holds an entry and trades it with its neighbors
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occ,
  input  data_t     new_data,
  input  prio_t     new_prio,
  input  logic      left_keep,
  input  data_t     left_data,
  input  prio_t     left_prio,
  input  data_t     right_data,
  input  prio_t     right_prio,
  output logic      keep,
  output data_t     data,
  output prio_t     prio
);

  data_t data_next;
  prio_t prio_next;

  // entry stays in place on insert when it ranks at or above the new one
  assign keep = occ && (prio >= new_prio);

  always_comb begin
    data_next = data;
    prio_next = prio;
    if (ctl.insert) begin
      if (!keep) begin
        if (left_keep) begin
          data_next = new_data;
          prio_next = new_prio;
        end else begin
          data_next = left_data;
          prio_next = left_prio;
        end
      end
    end else if (ctl.pop) begin
      data_next = right_data;
      prio_next = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    prio <= prio_next;
  end

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the stable priority queue with its scoreboard
module tb
  import spq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    data_t   front;
    status_t st;
    cnt_t    occ;
  } result_word_t;

  class sorted_queue_board;
    data_t        slot_data [CAPACITY];
    prio_t        slot_prio [CAPACITY];
    int           count;
    result_word_t expected_words[$];
    int           mismatches;

    function new();
      count      = 0;
      mismatches = 0;
    endfunction

    function void apply_word(cmd_t c, data_t d, logic [15:0] p);
      result_word_t r;
      int           pos;
      prio_t        pr;
      pr      = prio_t'(p);
      r.front = '0;
      r.st    = ST_OK;
      if (c == CMD_INSERT) begin
        if (count >= CAPACITY) begin
          r.st = ST_FULL;
        end else begin
          pos = 0;
          while (pos < count && slot_prio[pos] >= pr) pos++;
          for (int k = count; k > pos; k--) begin
            slot_data[k] = slot_data[k-1];
            slot_prio[k] = slot_prio[k-1];
          end
          slot_data[pos] = d;
          slot_prio[pos] = pr;
          count++;
        end
      end else begin
        if (count == 0) begin
          r.st = ST_EMPTY;
        end else begin
          r.front = slot_data[0];
          for (int k = 1; k < count; k++) begin
            slot_data[k-1] = slot_data[k];
            slot_prio[k-1] = slot_prio[k];
          end
          count--;
        end
      end
      r.occ = cnt_t'(count);
      expected_words.push_back(r);
    endfunction

    function void check_word(data_t fd, logic [1:0] st, logic [4:0] occ);
      result_word_t r;
      if (expected_words.size() == 0) begin
        $error("result word with no expected word: front_data %0d status %0d occupancy %0d",
               fd, st, occ);
        mismatches++;
      end else begin
        r = expected_words.pop_front();
        if (fd !== r.front) begin
          $error("front_data: expected %0d, got %0d", r.front, fd);
          mismatches++;
        end
        if (st !== r.st) begin
          $error("status: expected %0d, got %0d", r.st, st);
          mismatches++;
        end
        if (occ !== r.occ) begin
          $error("occupancy: expected %0d, got %0d", r.occ, occ);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               cmd = 1'b0;
  logic signed [31:0] entry_data = '0;
  logic [15:0]        entry_priority = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] front_data;
  logic [1:0]         status;
  logic [4:0]         occupancy;

  sorted_queue_board board = new();
  int                rx_cycle = 0;
  int                rx_mode = 0;

  stable_priority_queue uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .entry_data     (entry_data),
    .entry_priority (entry_priority),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .front_data     (front_data),
    .status         (status),
    .occupancy      (occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: checks each taken result word and switches among four stall patterns
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_word(front_data, status, occupancy);
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (rx_cycle % 5 != 0);
    endcase
  end

  task automatic send_word(cmd_t c, data_t d, logic [15:0] p);
    in_valid       <= 1'b1;
    cmd            <= c;
    entry_data     <= d;
    entry_priority <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.apply_word(c, d, p);
  endtask

  task automatic idle_sender(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_priority();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom);
      default: return 16'($urandom_range(0, 7));
    endcase
  endfunction

  initial begin
    int   sent;
    int   burst_left;
    int   gap;
    int   phase_kind;
    int   phase_len;
    int   insert_odds;
    cmd_t c;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty pop, extremes, equal priorities
    send_word(CMD_POP, 32'sh1234_5678, 16'h00AA);
    send_word(CMD_INSERT, 32'sh7FFF_FFFF, 16'h0005);
    send_word(CMD_INSERT, 32'sh8000_0000, 16'h0005);
    send_word(CMD_INSERT, 32'sh0000_0000, 16'hFFFF);
    send_word(CMD_INSERT, -32'sd1, 16'h0000);
    send_word(CMD_INSERT, 32'sh5555_5555, 16'h0005);
    send_word(CMD_INSERT, 32'shAAAA_AAAA, 16'hFFFF);
    send_word(CMD_INSERT, 32'sh0000_0001, 16'h0000);
    idle_sender(3);
    repeat (7) send_word(CMD_POP, '1, 16'hFFFF);
    send_word(CMD_POP, '0, 16'h0000);
    send_word(CMD_INSERT, 32'sh0F0F_0F0F, 16'h8000);
    send_word(CMD_POP, 32'sh7FFF_FFFF, 16'h7FFF);
    send_word(CMD_POP, '0, 16'h0000);

    // random phases: fill-heavy, drain-heavy, balanced
    sent       = 0;
    burst_left = $urandom_range(1, 24);
    while (sent < 1040) begin
      phase_kind = $urandom_range(0, 2);
      phase_len  = $urandom_range(20, 60);
      case (phase_kind)
        0: insert_odds = 85;
        1: insert_odds = 20;
        default: insert_odds = 50;
      endcase
      repeat (phase_len) begin
        c = ($urandom_range(1, 100) <= insert_odds) ? CMD_INSERT : CMD_POP;
        send_word(c, $urandom, pick_priority());
        sent++;
        burst_left--;
        if (burst_left == 0) begin
          gap = $urandom_range(0, 6);
          if (gap > 0) idle_sender(gap);
          burst_left = $urandom_range(1, 24);
        end
      end
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/stable_priority_queue.sv
tb/tb.sv
